@@ hdl/fixed_to_decimal_ascii_top_assert.svh @@
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_top_assert.svh
// Assertion macros used by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define FIXED_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FTDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ftda assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FTDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ftda assertion failed");

`endif

@@ hdl/ftda_pkg.sv @@
// ----------------------------------------------------------------------------
// ftda_pkg
// Types and constants for the fixed-point to decimal ASCII converter.
// ----------------------------------------------------------------------------
package ftda_pkg;

   localparam int INT_DIGITS = 10;
   localparam int FRAC_BITS  = 32;
   localparam int PREC_MAX   = 20;

   localparam int WORD_W  = 32;
   localparam int PREC_W  = 5;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 8;
   localparam int CNT_W   = $clog2(INT_DIGITS + 1);
   localparam int IDX_W   = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;

   localparam logic [PREC_W-1:0] PRECISION_RESET = 5'd6;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
   localparam logic [WORD_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                RECIP_SHIFT = 35;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   typedef struct packed {
      logic              negative;
      logic [WORD_W-1:0] int_magnitude;
      logic [WORD_W-1:0] frac_magnitude;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_INT,
      ST_POINT,
      ST_FRAC
   } state_type;

   typedef enum logic {
      OP_DIV10,
      OP_MUL10
   } unit_op_type;

   typedef struct packed {
      unit_op_type       op;
      logic [WORD_W-1:0] operand;
   } unit_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  result;
      logic [DIGIT_W-1:0] digit;
   } unit_rsp_type;

endpackage

@@ hdl/ftda_digit_unit.sv @@
// ----------------------------------------------------------------------------
// ftda_digit_unit
// Shared digit step: divide by ten (integer) or multiply by ten (fraction).
// ----------------------------------------------------------------------------
module ftda_digit_unit (
   input  ftda_pkg::unit_req_type unit_req,
   output ftda_pkg::unit_rsp_type unit_rsp
);
   import ftda_pkg::*;

   logic [2*WORD_W-1:0]        product;
   logic [WORD_W-1:0]          quotient;
   logic [WORD_W-1:0]          remainder;
   logic [FRAC_BITS+DIGIT_W-1:0] scaled;

   // reciprocal multiply, then remainder by shift-add of quotient * 10
   assign product   = {{WORD_W{1'b0}}, unit_req.operand} * {{WORD_W{1'b0}}, RECIP_TEN};
   assign quotient  = WORD_W'(product >> RECIP_SHIFT);
   assign remainder = unit_req.operand - (quotient << 3) - (quotient << 1);

   // fraction * 10: integer part lands in the top nibble
   assign scaled = ((FRAC_BITS+DIGIT_W)'(unit_req.operand[FRAC_BITS-1:0]) << 3)
                 + ((FRAC_BITS+DIGIT_W)'(unit_req.operand[FRAC_BITS-1:0]) << 1);

   always_comb begin
      case (unit_req.op)
         OP_DIV10: begin
            unit_rsp.result = quotient;
            unit_rsp.digit  = remainder[DIGIT_W-1:0];
         end
         default: begin
            unit_rsp.result = WORD_W'(scaled[FRAC_BITS-1:0]);
            unit_rsp.digit  = scaled[FRAC_BITS+DIGIT_W-1:FRAC_BITS];
         end
      endcase
   end

endmodule

@@ hdl/fixed_to_decimal_ascii_top.sv @@
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_top
// Converts a sign-magnitude fixed-point number to decimal ASCII text.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload         | meaning
//  --------+-----+-----------------+-----------------------------------------
//  req_    | in  | req_type        | one number: sign, integer, 2^-32 fraction
//  rsp_    | out | rsp_type        | one character per transfer, last flagged
//  csr_    | in  | 5-bit precision | fraction digit count (reset 6, max 20)
//
//  Sequence: accept, then D divide steps (D = integer digit count, 1..10),
//  then the characters in order (sign if negative, D digits, and, when P
//  is not zero, the point and P fraction digits); the shared digit unit
//  serves the divide and fraction steps, and the output register holds one.
//  req_ready is high only in idle; rsp stalls simply hold the sequencer.
//  Reset (synchronous) clears the sequencer and output valid, and sets
//  precision to 6.
// ----------------------------------------------------------------------------
`include "fixed_to_decimal_ascii_top_assert.svh"

module fixed_to_decimal_ascii_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ftda_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ftda_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ftda_pkg::PREC_W-1:0]        csr_data
);
   import ftda_pkg::*;

   state_type           state_ff,     state_in;
   logic [PREC_W-1:0]   precision_ff;
   logic                negative_ff,  negative_in;
   logic [WORD_W-1:0]   int_rem_ff,   int_rem_in;
   logic [FRAC_BITS-1:0] frac_rem_ff, frac_rem_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [PREC_W-1:0]   frac_left_ff, frac_left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff,  rsp_data_in;
   logic [DIGIT_W-1:0]  digit_buf_ff [INT_DIGITS];

   logic                buf_we;
   logic [IDX_W-1:0]    rd_idx;
   logic [CNT_W-1:0]    count_inc;
   logic [PREC_W-1:0]   prec_sat;
   logic                load;
   unit_req_type        unit_req;
   unit_rsp_type        unit_rsp;

   ftda_digit_unit u_digit_unit (
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // output register takes a new character when empty or being drained
   assign load      = !rsp_valid_ff || rsp_ready;
   assign count_inc = count_ff + CNT_W'(1);
   assign rd_idx    = IDX_W'(count_ff - CNT_W'(1));
   assign prec_sat  = (precision_ff > PREC_W'(PREC_MAX)) ? PREC_W'(PREC_MAX)
                                                          : precision_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         precision_ff <= PRECISION_RESET;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         frac_left_ff <= '0;
         int_rem_ff   <= '0;
         frac_rem_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         frac_left_ff <= frac_left_in;
         int_rem_ff   <= int_rem_in;
         frac_rem_ff  <= frac_rem_in;
         if (csr_valid && csr_ready) begin
            precision_ff <= csr_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      negative_ff <= negative_in;
      rsp_data_ff <= rsp_data_in;
      if (buf_we) begin
         digit_buf_ff[count_ff[IDX_W-1:0]] <= unit_rsp.digit;
      end
   end

   always_comb begin
      state_in      = state_ff;
      negative_in   = negative_ff;
      int_rem_in    = int_rem_ff;
      frac_rem_in   = frac_rem_ff;
      count_in      = count_ff;
      frac_left_in  = frac_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      buf_we        = 1'b0;
      unit_req.op      = OP_DIV10;
      unit_req.operand = int_rem_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               negative_in  = req_data.negative;
               int_rem_in   = req_data.int_magnitude;
               frac_rem_in  = req_data.frac_magnitude[FRAC_BITS-1:0];
               frac_left_in = prec_sat;
               count_in     = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // one integer digit per cycle, least significant first
            buf_we     = 1'b1;
            int_rem_in = unit_rsp.result;
            count_in   = count_inc;
            if (unit_rsp.result == '0 || count_inc == CNT_W'(INT_DIGITS)) begin
               state_in = negative_ff ? ST_SIGN : ST_INT;
            end
         end
         ST_SIGN: begin
            if (load) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.char_code = ASCII_MINUS;
               rsp_data_in.last      = 1'b0;
               state_in              = ST_INT;
            end
         end
         ST_INT: begin
            // digits leave most significant first
            if (load) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.char_code = ASCII_ZERO + CHAR_W'(digit_buf_ff[rd_idx]);
               rsp_data_in.last      = 1'b0;
               count_in              = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  if (frac_left_ff == '0) begin
                     rsp_data_in.last = 1'b1;
                     state_in         = ST_IDLE;
                  end else begin
                     state_in = ST_POINT;
                  end
               end
            end
         end
         ST_POINT: begin
            if (load) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.char_code = ASCII_POINT;
               rsp_data_in.last      = 1'b0;
               state_in              = ST_FRAC;
            end
         end
         ST_FRAC: begin
            // truncated fraction digit per multiply-by-ten
            unit_req.op      = OP_MUL10;
            unit_req.operand = WORD_W'(frac_rem_ff);
            if (load) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.char_code = ASCII_ZERO + CHAR_W'(unit_rsp.digit);
               rsp_data_in.last      = (frac_left_ff == PREC_W'(1));
               frac_rem_in           = unit_rsp.result[FRAC_BITS-1:0];
               frac_left_in          = frac_left_ff - PREC_W'(1);
               if (frac_left_ff == PREC_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `FTDA_ASSERT_NEXT(a_accept_divides, clock, reset, req_valid && req_ready, state_ff == ST_DIVIDE)
   `FTDA_ASSERT_NOW(a_divide_in_range, clock, reset, state_ff == ST_DIVIDE, count_ff < CNT_W'(INT_DIGITS))
   `FTDA_ASSERT_NOW(a_int_has_digit, clock, reset, state_ff == ST_INT, count_ff != '0)
   `FTDA_ASSERT_NOW(a_frac_has_digit, clock, reset, state_ff == ST_FRAC, frac_left_ff != '0)

endmodule

@@ dv/fixed_to_decimal_ascii_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_top_tb
// Drives sign-magnitude fixed-point numbers into the converter and checks
// every emitted character against a local prediction of the decimal text.
// Precision is changed only while the converter is idle. Both sides stall
// in random bursts, except in the final stretch.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_top_tb;
   import ftda_pkg::*;

   localparam int CLK_PERIOD  = 20;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD   = 300;
   localparam int MAX_CHARS   = 1 + INT_DIGITS + 1 + PREC_MAX;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [PREC_W-1:0]   csr_data;

   // Predicted characters, oldest first, and our copy of the precision register.
   rsp_type             expected_chars[$];
   logic [PREC_W-1:0]   precision_setting;

   int                  mismatch_count;
   int                  cycle_count;

   // Idling knobs shared by the request and response sides.
   int                  req_gap_pct;
   int                  rsp_stall_pct;
   bit                  quiet_mode;
   int                  long_hold_cycles;

   fixed_to_decimal_ascii_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Text prediction: sign, integer digits by divide-by-ten (no leading
   // zeros, a lone '0' for zero), then, at nonzero precision, '.' and truncated
   // fraction digits by multiply-by-ten. Over-maximum precision saturates.
   // ------------------------------------------------------------------------
   task automatic predict_text(input req_type item);
      rsp_type            chars[MAX_CHARS];
      logic [DIGIT_W-1:0] digits[INT_DIGITS];
      logic [WORD_W-1:0]  rem;
      logic [63:0]        frac;
      logic [63:0]        frac_mask;
      logic [DIGIT_W-1:0] digit;
      logic [PREC_W-1:0]  prec;
      int                 n;
      int                 dcount;
      n = 0;
      prec = (precision_setting > PREC_MAX) ? PREC_W'(PREC_MAX) : precision_setting;
      frac_mask = (FRAC_BITS >= 32) ? 64'h0000_0000_FFFF_FFFF
                                    : ((64'd1 << FRAC_BITS) - 64'd1);
      // negative zero still gets its minus sign
      if (item.negative) begin
         chars[n].char_code = ASCII_MINUS;
         n++;
      end
      rem = item.int_magnitude;
      dcount = 0;
      do begin
         digits[dcount] = DIGIT_W'(rem % 10);
         rem = rem / 10;
         dcount++;
      end while (rem != 0 && dcount < INT_DIGITS);
      for (int i = dcount - 1; i >= 0; i--) begin
         chars[n].char_code = ASCII_ZERO + CHAR_W'(digits[i]);
         n++;
      end
      // fraction bits at or above FRAC_BITS are dropped
      frac = {32'd0, item.frac_magnitude} & frac_mask;
      if (prec != 0) begin
         chars[n].char_code = ASCII_POINT;
         n++;
         for (int i = 0; i < prec; i++) begin
            frac = frac * 64'd10;
            digit = DIGIT_W'(frac >> FRAC_BITS);
            frac = frac & frac_mask;
            chars[n].char_code = ASCII_ZERO + CHAR_W'(digit);
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         chars[i].last = (i == n - 1);
         expected_chars.push_back(chars[i]);
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side. Valid stays up across back-to-back requests; it drops only
   // for a random gap after an accepted request or in wait_for_text_done.
   // ------------------------------------------------------------------------
   task automatic send_number(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_text(item);
      if (!quiet_mode && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic neg, input logic [WORD_W-1:0] ipart,
                              input logic [WORD_W-1:0] fpart);
      req_type item;
      item.negative       = neg;
      item.int_magnitude  = ipart;
      item.frac_magnitude = fpart;
      send_number(item);
   endtask

   // Idle the request side and wait until every predicted character is out.
   task automatic wait_for_text_done();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Only called with the converter idle, never twice in a row.
   task automatic write_precision(input logic [PREC_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      precision_setting = value;
   endtask

   // Half digit-count boundaries and small values, half full random.
   function automatic req_type random_number();
      req_type           item;
      logic [WORD_W-1:0] pow;
      int                k;
      item.negative = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: begin
            item.int_magnitude = $urandom_range(0, 9);
         end
         1: begin
            k = $urandom_range(0, 9);
            pow = 1;
            for (int i = 0; i < k; i++) pow = pow * 10;
            item.int_magnitude = $urandom_range(0, 1) ? pow : pow - 1;
         end
         default: begin
            item.int_magnitude = $urandom;
         end
      endcase
      case ($urandom_range(0, 4))
         0:       item.frac_magnitude = '0;
         1:       item.frac_magnitude = '1;
         default: item.frac_magnitude = $urandom;
      endcase
      return item;
   endfunction

   function automatic logic [PREC_W-1:0] random_precision();
      // mostly legal values, sometimes above the saturation point
      if ($urandom_range(0, 4) == 0) return PREC_W'($urandom_range(PREC_MAX + 1, 31));
      return PREC_W'($urandom_range(0, PREC_MAX));
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stall bursts, plus one long hold-off on request.
   // The hold is counted here so the sender keeps pushing meanwhile.
   // ------------------------------------------------------------------------
   initial begin
      int hold;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold_cycles != 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet_mode && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Character checker: each accepted character against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected char: got code %02h last %0b",
                        rsp_data.char_code, rsp_data.last);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.char_code !== want.char_code || rsp_data.last !== want.last) begin
               if (mismatch_count < 10)
                  $display("char mismatch: expected code %02h last %0b, got code %02h last %0b",
                           want.char_code, want.last, rsp_data.char_code, rsp_data.last);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset precision of 6: zero, negative zero, full-scale values, digit edges.
   task automatic test_reset_precision();
      send_fields(1'b0, 32'd0, 32'd0);
      send_fields(1'b1, 32'd0, 32'd0);
      send_fields(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(1'b0, 32'd123, 32'h8000_0000);
      send_fields(1'b0, 32'd9, 32'd1);
      send_fields(1'b1, 32'd10, 32'h1999_999A);
      wait_for_text_done();
   endtask

   // Precision 0 (no point), the maximum, saturation above it, and 1.
   task automatic test_precision_extremes();
      write_precision(PREC_W'(0));
      send_fields(1'b0, 32'd0, 32'h8000_0000);
      send_fields(1'b1, 32'hFFFF_FFFF, 32'd0);
      send_fields(1'b0, 32'd1000000000, 32'hFFFF_FFFF);
      wait_for_text_done();
      write_precision(PREC_W'(PREC_MAX));
      send_fields(1'b0, 32'd0, 32'hFFFF_FFFF);
      send_fields(1'b1, 32'd0, 32'd1);
      send_fields(1'b0, 32'd99999, 32'h5555_5555);
      wait_for_text_done();
      write_precision(PREC_W'(31));
      send_fields(1'b0, 32'd7, 32'hAAAA_AAAA);
      send_fields(1'b1, 32'd0, 32'd0);
      wait_for_text_done();
      write_precision(PREC_W'(1));
      send_fields(1'b0, 32'd5, 32'hE666_6666);
      send_fields(1'b0, 32'd0, 32'h1999_9999);
      wait_for_text_done();
   endtask

   // Random numbers in blocks, each block at a fresh precision and idle mix.
   task automatic test_random_blocks(input int blocks, input int per_block);
      for (int b = 0; b < blocks; b++) begin
         write_precision(random_precision());
         case ($urandom_range(0, 2))
            0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_gap_pct = 20; rsp_stall_pct = 20; end
            default: begin req_gap_pct = 50; rsp_stall_pct = 50; end
         endcase
         repeat (per_block) send_number(random_number());
         wait_for_text_done();
      end
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      write_precision(PREC_W'(PREC_MAX));
      req_gap_pct = 0;
      long_hold_cycles = LONG_HOLD;
      repeat (8) send_number(random_number());
      wait_for_text_done();
   endtask

   // Sender stops mid-stream until all text is out, then resumes.
   task automatic test_sender_pause();
      write_precision(random_precision());
      req_gap_pct = 30;
      rsp_stall_pct = 30;
      repeat (10) send_number(random_number());
      wait_for_text_done();
      repeat (10) send_number(random_number());
      wait_for_text_done();
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_full_rate();
      write_precision(random_precision());
      quiet_mode = 1'b1;
      repeat (30) send_number(random_number());
      wait_for_text_done();
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_valid      <= 1'b0;
      csr_data       <= '0;
      mismatch_count = 0;
      cycle_count    = 0;
      req_gap_pct    = 25;
      rsp_stall_pct  = 25;
      quiet_mode     = 1'b0;
      long_hold_cycles = 0;
      precision_setting = PRECISION_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_precision();
      test_precision_extremes();
      test_random_blocks(8, 25);
      test_output_backpressure();
      test_sender_pause();
      test_full_rate();

      // let any stray character surface before the verdict
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
